/* hw/rtl/sapid_pkg.sv */
// Shared types and constants for the six-axis PID controller.
package sapid_pkg;

   // Request kinds carried on req_tuser
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   // Gain selectors within one axis row of the gain table
   localparam logic [1:0] TERM_P    = 2'd0;
   localparam logic [1:0] TERM_I    = 2'd1;
   localparam logic [1:0] TERM_D    = 2'd2;
   localparam logic [1:0] TERM_NONE = 2'd3;

   // Configuration register indexes
   localparam logic CSR_INTEGRAL_LIMIT = 1'b0;
   localparam logic CSR_SAMPLE_PERIOD  = 1'b1;

   localparam int LIMIT_W  = 31;
   localparam int PERIOD_W = 24;
   localparam int DATA_W   = 32;
   localparam int AXIS_F_W = 3;
   localparam int MUL_W    = 33;
   localparam int PROD_W   = 2 * MUL_W;
   localparam int ACC_W    = 51;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

   // Write controls of a state memory
   typedef struct packed {
      logic wr_en;
      logic clear;
   } mem_ctl_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_INT   = 6'b000010,
      ST_PROP  = 6'b000100,
      ST_INTG  = 6'b001000,
      ST_DERIV = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

endpackage

/* hw/rtl/sapid_vmem.sv */
// Synchronous memory, one write and one registered read port, per-entry valid bits.
module sapid_vmem #(
   parameter int DEPTH = 6,
   parameter int WIDTH = 64,
   parameter int AW    = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sapid_pkg::mem_ctl_type   ctl,
   input  logic [AW-1:0]            waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [AW-1:0]            raddr,
   output logic [WIDTH-1:0]         rdata
);
   import sapid_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] mem_q_ff;
   logic             vld_q_ff;

   // entries not written since reset or clear read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.clear) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[waddr] <= wdata;
      end
      mem_q_ff <= mem[raddr];
      vld_q_ff <= vld_ff[raddr];
   end

   assign rdata = vld_q_ff ? mem_q_ff : '0;

endmodule

/* hw/rtl/sapid_mul.sv */
// Shared signed 33x33 multiplier with registered product.
module sapid_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [sapid_pkg::MUL_W-1:0]  op_a,
   input  logic signed [sapid_pkg::MUL_W-1:0]  op_b,
   output logic signed [sapid_pkg::PROD_W-1:0] prod
);
   import sapid_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= PROD_W'(op_a) * PROD_W'(op_b);
      end
   end

   assign prod = prod_ff;

endmodule

/* hw/rtl/six_axis_pid_with_integrator_clamp.sv */
// Six-axis PID controller with integrator clamp: control, datapath and state memories.
//
//  channel  | direction | contents
//  ---------+-----------+-----------------------------------------------------
//  req_*    | in        | sample (func 0) or gain load (func 1), stream transfer
//  rsp_*    | out       | axis, saturated command, clamped integral
//  csr_*    | in        | write-only: 0 integral_limit, 1 sample_period
//
// A sample runs through the states INT, PROP, INTG, DERIV and DONE: the four
// products (error*period, Kp, Ki, Kd) go one per cycle through a single
// 33x33 multiplier, each behind a registered read of the state/gain memories,
// then DONE sums and saturates and places the result in the result register.
// A hold sample goes from IDLE straight to DONE; a gain load is written at
// its transfer and leaves the block idle.
// One item is in work at a time; a finished result waits in its last state
// until the output register is free, and a new item is taken once the
// previous one has been placed there.
// Reset is synchronous and holds req_tready low; the memories use per-entry
// valid bits, so there is no clearing pass and the block is ready in the
// cycle after reset.
module six_axis_pid_with_integrator_clamp #(
   parameter int AXES = 6
) (
   input  logic         clock,
   input  logic         reset,
   // configuration
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [30:0]  csr_wdata,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: axis[2:0], measured[34:3], desired[66:35], hold[67],
   //        gain_term[69:68], gain_value[101:70], zero pad[103:102]
   input  logic [103:0] req_tdata,
   // tuser: func[0]
   input  logic         req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: out_axis[2:0], command[34:3], integral_now[66:35], zero pad[71:67]
   output logic [71:0]  rsp_tdata
);
   import sapid_pkg::*;

   localparam int AXIS_W  = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int GAINS   = 3 * AXES;
   localparam int GAIN_AW = (GAINS > 1) ? $clog2(GAINS) : 1;
   localparam int ST_W    = 2 * DATA_W;

   // request fields
   logic [AXIS_F_W-1:0]      req_axis;
   logic signed [DATA_W-1:0] req_measured;
   logic signed [DATA_W-1:0] req_desired;
   logic                     req_hold;
   logic [1:0]               req_term;
   logic signed [DATA_W-1:0] req_gain;
   logic                     req_func;

   assign req_axis     = req_tdata[2:0];
   assign req_measured = req_tdata[34:3];
   assign req_desired  = req_tdata[66:35];
   assign req_hold     = req_tdata[67];
   assign req_term     = req_tdata[69:68];
   assign req_gain     = req_tdata[101:70];
   assign req_func     = req_tuser;

   // registers
   state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]       limit_ff;
   logic [PERIOD_W-1:0]      period_ff;
   logic [AXIS_F_W-1:0]      axis_ff, axis_in;
   logic signed [DATA_W-1:0] value_ff, value_in;   // desired, or measured on hold
   logic                     hold_ff, hold_in;
   logic signed [DATA_W-1:0] err_ff, err_in;
   logic signed [DATA_W:0]   deriv_ff, deriv_in;
   logic signed [DATA_W-1:0] integ_old_ff, integ_old_in;
   logic signed [DATA_W-1:0] integ_ff, integ_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [AXIS_F_W-1:0]      rsp_axis_ff, rsp_axis_in;
   logic signed [DATA_W-1:0] rsp_cmd_ff, rsp_cmd_in;
   logic signed [DATA_W-1:0] rsp_integ_ff, rsp_integ_in;

   // memory and multiplier hookup
   mem_ctl_type               st_ctl, gn_ctl;
   logic [AXIS_W-1:0]         st_waddr, st_raddr;
   logic [ST_W-1:0]           st_wdata, st_rdata;
   logic [GAIN_AW-1:0]        gn_waddr, gn_raddr;
   logic [DATA_W-1:0]         gn_rdata;
   logic signed [DATA_W-1:0]  gain_q;
   logic signed [DATA_W-1:0]  prev_q;
   logic signed [DATA_W-1:0]  integ_q;
   logic [1:0]                term_sel;
   logic                      mul_en;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod;

   // arithmetic
   logic                      req_xfer;
   logic                      axis_ok;
   logic signed [DATA_W:0]    diff;
   logic signed [DATA_W-1:0]  err_sat;
   logic signed [PROD_W-1:0]  prod_r24, prod_r16;
   logic signed [DATA_W:0]    inc;
   logic signed [DATA_W+1:0]  isum, lim_pos, lim_neg;
   logic signed [DATA_W-1:0]  integ_new;
   logic signed [ACC_W-1:0]   term_rnd;
   logic signed [ACC_W-1:0]   final_sum;
   logic signed [DATA_W-1:0]  cmd_sat;
   logic                      out_free;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_xfer   = req_tvalid && req_tready;
   assign axis_ok    = (32'(req_axis) < AXES);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // error, saturated to 32 bits
   assign diff    = (DATA_W+1)'(req_desired) - (DATA_W+1)'(req_measured);
   assign err_sat = (diff[DATA_W] != diff[DATA_W-1])
                    ? {diff[DATA_W], {(DATA_W-1){~diff[DATA_W]}}}
                    : diff[DATA_W-1:0];

   // round half up, then integrator clamp
   assign prod_r24  = (prod + (PROD_W'(1) <<< 23)) >>> 24;
   assign prod_r16  = (prod + (PROD_W'(1) <<< 15)) >>> 16;
   assign inc       = prod_r24[DATA_W:0];
   assign isum      = (DATA_W+2)'(integ_old_ff) + (DATA_W+2)'(inc);
   assign lim_pos   = (DATA_W+2)'({1'b0, limit_ff});
   assign lim_neg   = -lim_pos;
   always_comb begin
      if (isum > lim_pos) begin
         integ_new = lim_pos[DATA_W-1:0];
      end else if (isum < lim_neg) begin
         integ_new = lim_neg[DATA_W-1:0];
      end else begin
         integ_new = isum[DATA_W-1:0];
      end
   end

   assign term_rnd  = prod_r16[ACC_W-1:0];
   assign final_sum = acc_ff + term_rnd;
   always_comb begin
      if (final_sum > ACC_W'(32'sh7fffffff)) begin
         cmd_sat = 32'sh7fffffff;
      end else if (final_sum < -ACC_W'(64'sh80000000)) begin
         cmd_sat = 32'sh80000000;
      end else begin
         cmd_sat = final_sum[DATA_W-1:0];
      end
   end

   // memory read data: state word is {integral, previous error}
   assign prev_q  = st_rdata[DATA_W-1:0];
   assign integ_q = st_rdata[ST_W-1:DATA_W];
   assign gain_q  = gn_rdata;

   // state memory: read at the transfer, written back once the integral is known
   assign st_raddr    = AXIS_W'((state_ff == ST_IDLE) ? req_axis : axis_ff);
   assign st_waddr    = AXIS_W'(axis_ff);
   assign st_wdata    = {integ_new, err_ff};
   assign st_ctl.wr_en = (state_ff == ST_PROP);
   assign st_ctl.clear = req_xfer && (req_func == FUNC_SAMPLE) && req_hold;

   // gain table: loads written at the transfer, gains read one per cycle
   always_comb begin
      case (state_ff)
         ST_INT:  term_sel = TERM_P;
         ST_PROP: term_sel = TERM_I;
         default: term_sel = TERM_D;
      endcase
   end
   assign gn_raddr     = GAIN_AW'(32'(axis_ff) * 3 + 32'(term_sel));
   assign gn_waddr     = GAIN_AW'(32'(req_axis) * 3 + 32'(req_term));
   assign gn_ctl.wr_en = req_xfer && (req_func == FUNC_LOAD) && axis_ok
                         && (req_term != TERM_NONE);
   assign gn_ctl.clear = 1'b0;

   // multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      case (state_ff)
         ST_INT: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'({1'b0, period_ff});
         end
         ST_PROP: begin
            mul_a = MUL_W'(gain_q);
            mul_b = MUL_W'(err_ff);
         end
         ST_INTG: begin
            mul_a = MUL_W'(gain_q);
            mul_b = MUL_W'(integ_ff);
         end
         ST_DERIV: begin
            mul_a = MUL_W'(gain_q);
            mul_b = deriv_ff;
         end
         default: begin
            mul_en = 1'b0;
            mul_a  = '0;
            mul_b  = '0;
         end
      endcase
   end

   sapid_vmem #(
      .DEPTH (AXES),
      .WIDTH (ST_W),
      .AW    (AXIS_W)
   ) u_state_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (st_ctl),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   sapid_vmem #(
      .DEPTH (GAINS),
      .WIDTH (DATA_W),
      .AW    (GAIN_AW)
   ) u_gain_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (gn_ctl),
      .waddr (gn_waddr),
      .wdata (req_gain),
      .raddr (gn_raddr),
      .rdata (gn_rdata)
   );

   sapid_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      value_in     = value_ff;
      hold_in      = hold_ff;
      err_in       = err_ff;
      deriv_in     = deriv_ff;
      integ_old_in = integ_old_ff;
      integ_in     = integ_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_axis_in  = rsp_axis_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_integ_in = rsp_integ_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_func == FUNC_SAMPLE) && axis_ok) begin
               axis_in = req_axis;
               hold_in = req_hold;
               if (req_hold) begin
                  value_in = req_measured;
                  integ_in = '0;
                  state_in = ST_DONE;
               end else begin
                  value_in = req_desired;
                  err_in   = err_sat;
                  state_in = ST_INT;
               end
            end
         end
         ST_INT: begin
            // state read data is here; multiplier takes error * period
            deriv_in     = (DATA_W+1)'(err_ff) - (DATA_W+1)'(prev_q);
            integ_old_in = integ_q;
            state_in     = ST_PROP;
         end
         ST_PROP: begin
            integ_in = integ_new;
            state_in = ST_INTG;
         end
         ST_INTG: begin
            acc_in   = ACC_W'(value_ff) + term_rnd;
            state_in = ST_DERIV;
         end
         ST_DERIV: begin
            acc_in   = acc_ff + term_rnd;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_axis_in  = axis_ff;
               rsp_cmd_in   = hold_ff ? value_ff : cmd_sat;
               rsp_integ_in = integ_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= '0;
         period_ff    <= PERIOD_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INTEGRAL_LIMIT: limit_ff  <= csr_wdata;
               CSR_SAMPLE_PERIOD:  period_ff <= csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      axis_ff      <= axis_in;
      value_ff     <= value_in;
      hold_ff      <= hold_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      integ_old_ff <= integ_old_in;
      integ_ff     <= integ_in;
      acc_ff       <= acc_in;
      rsp_axis_ff  <= rsp_axis_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_integ_ff <= rsp_integ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_integ_ff, rsp_cmd_ff, rsp_axis_ff};

endmodule

/* verif/six_axis_pid_with_integrator_clamp_tb.sv */
// Self-checking testbench for the six-axis PID controller with integrator clamp.
module six_axis_pid_with_integrator_clamp_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sapid_pkg::*;

   localparam int          AXES        = 6;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int          PHASE_ITEMS = 237;
   // loads and out-of-range samples give no result but may still be in work
   localparam int          SETTLE_CYCLES = 10;

   // one request as the sender sees it
   typedef struct {
      logic               func;
      logic [2:0]         axis;
      logic signed [31:0] measured;
      logic signed [31:0] desired;
      logic               hold;
      logic [1:0]         gain_term;
      logic signed [31:0] gain_value;
   } pid_req_type;

   // one expected command transfer
   typedef struct {
      logic [2:0]         axis;
      logic signed [31:0] command;
      logic signed [31:0] integral;
   } pid_cmd_type;

   // Tracks the controller's memories and the commands still owed by the block.
   class pid_command_book;
      longint      prev_err [AXES];
      longint      integ    [AXES];
      longint      gains    [3*AXES];
      longint      limit;
      longint      period;
      pid_cmd_type due_commands[$];
      int          mismatch_count;

      function new();
         foreach (prev_err[i]) prev_err[i] = 0;
         foreach (integ[i]) integ[i] = 0;
         foreach (gains[i]) gains[i] = 0;
         limit = 0;
         period = 16777;
         mismatch_count = 0;
      endfunction

      function void set_register(logic idx, logic [30:0] val);
         if (idx == CSR_INTEGRAL_LIMIT) limit = longint'(val);
         else period = longint'(val[23:0]);
      endfunction

      // floor(x / 2^s + 1/2)
      function longint round_q(longint x, int s);
         return (x + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint clamp32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      function void accept_request(pid_req_type r);
         longint      err, deriv, acc, up, ui, ud, cmd, meas, des;
         int          a;
         pid_cmd_type c;
         a = r.axis;
         if (r.func == FUNC_LOAD) begin
            if (a < AXES && r.gain_term != TERM_NONE)
               gains[a*3 + r.gain_term] = r.gain_value;
            return;
         end
         if (r.hold) begin
            foreach (prev_err[i]) prev_err[i] = 0;
            foreach (integ[i]) integ[i] = 0;
            if (a >= AXES) return;
            c.axis = r.axis;
            c.command = r.measured;
            c.integral = 0;
            due_commands = {due_commands, c};
            return;
         end
         if (a >= AXES) return;
         meas = r.measured;
         des = r.desired;
         err = clamp32(des - meas);
         deriv = err - prev_err[a];
         prev_err[a] = err;
         acc = integ[a] + round_q(err * period, 24);
         if (acc > limit) acc = limit;
         else if (acc < -limit) acc = -limit;
         integ[a] = acc;
         up = round_q(gains[a*3 + TERM_P] * err, 16);
         ui = round_q(gains[a*3 + TERM_I] * acc, 16);
         ud = round_q(gains[a*3 + TERM_D] * deriv, 16);
         cmd = clamp32(des + up + ui + ud);
         c.axis = r.axis;
         c.command = cmd[31:0];
         c.integral = acc[31:0];
         due_commands = {due_commands, c};
      endfunction

      function void check_command(logic [71:0] d);
         pid_cmd_type e;
         if (due_commands.size() == 0) begin
            $error("unexpected result transfer: out_axis %0d command %0d integral_now %0d",
                   d[2:0], $signed(d[34:3]), $signed(d[66:35]));
            mismatch_count++;
            return;
         end
         e = due_commands.pop_front();
         if (d[2:0] !== e.axis) begin
            $error("out_axis: expected %0d, got %0d", e.axis, d[2:0]);
            mismatch_count++;
         end
         if (d[34:3] !== e.command) begin
            $error("command: expected %0d, got %0d", e.command, $signed(d[34:3]));
            mismatch_count++;
         end
         if (d[66:35] !== e.integral) begin
            $error("integral_now: expected %0d, got %0d", e.integral, $signed(d[66:35]));
            mismatch_count++;
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------------
   // Clock, reset and block inputs; everything starts at a known value
   // ---------------------------------------------------------------------------
   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         csr_wr_en  = 1'b0;
   logic         csr_index  = 1'b0;
   logic [30:0]  csr_wdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;   // axis, measured, desired, hold, gain_term, gain_value, pad
   logic         req_tuser  = 1'b0; // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [71:0]  rsp_tdata;         // out_axis, command, integral_now, pad

   // idle rates of the current phase, in percent of cycles
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;

   pid_command_book book;

   six_axis_pid_with_integrator_clamp #(.AXES(AXES)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: values read at the edge are the pre-edge ones, so a transfer
   // is seen exactly when tvalid and tready were both high going into it.
   // tready is redrawn every cycle so stalls land on any cycle of a result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_command(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic pid_req_type make_req(logic func, logic [2:0] axis,
                                            logic [31:0] measured, logic [31:0] desired,
                                            logic hold, logic [1:0] term,
                                            logic [31:0] gval);
      pid_req_type r;
      r.func = func;
      r.axis = axis;
      r.measured = measured;
      r.desired = desired;
      r.hold = hold;
      r.gain_term = term;
      r.gain_value = gval;
      return r;
   endfunction

   // Q16.16 operand: mostly within +/-16.0, sometimes the rails or anything.
   function automatic logic [31:0] pick_q16();
      int unsigned sel;
      sel = $urandom_range(9);
      case (sel)
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom();
         default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   // Mostly samples on valid axes, half with the desired value near the measured one,
   // so errors stay moderate and integrals build up between holds.
   function automatic pid_req_type rand_req();
      pid_req_type r;
      r.func = ($urandom_range(99) < 25) ? FUNC_LOAD : FUNC_SAMPLE;
      r.axis = ($urandom_range(99) < 6) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
      r.measured = pick_q16();
      if ($urandom_range(1)) r.desired = r.measured + ($urandom_range(32'h0008_0000) - 32'h0004_0000);
      else r.desired = pick_q16();
      r.hold = ($urandom_range(99) < 3);
      r.gain_term = 2'($urandom_range(3));
      if ($urandom_range(99) < 15) r.gain_value = $urandom();
      else r.gain_value = $urandom_range(32'h0008_0000) - 32'h0004_0000;
      return r;
   endfunction

   // One request transfer. tvalid is only lowered while idling, so a
   // back-to-back item never sees a lower and a raise in one time step.
   task automatic send_req(input pid_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.func;
      req_tdata <= {2'b00, r.gain_value, r.gain_term, r.hold, r.desired, r.measured, r.axis};
      do @(posedge clock); while (!req_tready);
      book.accept_request(r);
   endtask

   // Stop sending and wait until every owed command has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.due_commands.size() != 0);
   endtask

   task automatic write_csr(input logic idx, input logic [30:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.set_register(idx, val);
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      book = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: widest clamp and longest period, gains at the rails.
      write_csr(CSR_INTEGRAL_LIMIT, 31'h7FFF_FFFF);
      write_csr(CSR_SAMPLE_PERIOD, 31'h00FF_FFFF);
      send_req(make_req(FUNC_LOAD, 3'd0, 0, 0, 1'b0, TERM_P, 32'h7FFF_FFFF));
      send_req(make_req(FUNC_LOAD, 3'd0, 0, 0, 1'b0, TERM_I, 32'h8000_0000));
      // hold on a load does nothing
      send_req(make_req(FUNC_LOAD, 3'd0, 0, 0, 1'b1, TERM_D, 32'h7FFF_FFFF));
      send_req(make_req(FUNC_LOAD, 3'd5, 0, 0, 1'b0, TERM_P, 32'h0001_0000));
      send_req(make_req(FUNC_LOAD, 3'd5, 0, 0, 1'b0, TERM_I, 32'h0000_8000));
      send_req(make_req(FUNC_LOAD, 3'd5, 0, 0, 1'b0, TERM_D, 32'hFFFF_0000));
      // ignored loads: axis out of range, unused gain selector
      send_req(make_req(FUNC_LOAD, 3'd6, 0, 0, 1'b0, TERM_P, 32'h1234_5678));
      send_req(make_req(FUNC_LOAD, 3'd1, 0, 0, 1'b0, TERM_NONE, 32'h7FFF_FFFF));
      // error saturates both ways; derivative swings across the full range
      send_req(make_req(FUNC_SAMPLE, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd5, 32'h0003_8000, 32'hFFFE_4000, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd5, 32'hFFFE_4000, 32'h0003_8000, 1'b0, TERM_P, 0));
      // out-of-range sample: no result, memory kept
      send_req(make_req(FUNC_SAMPLE, 3'd7, 32'h0001_0000, 32'h0002_0000, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd5, 32'h0001_0000, 32'h0002_0000, 1'b0, TERM_P, 0));
      // out-of-range hold still clears every axis
      send_req(make_req(FUNC_SAMPLE, 3'd6, 32'h0001_0000, 32'h0002_0000, 1'b1, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd5, 32'h0001_0000, 32'h0002_0000, 1'b0, TERM_P, 0));
      // hold passes measured through
      send_req(make_req(FUNC_SAMPLE, 3'd5, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd0, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0, TERM_P, 0));
      send_req(make_req(FUNC_SAMPLE, 3'd3, 32'hFFFF_0000, 32'h0001_0000, 1'b0, TERM_P, 0));

      // Random phases, each with its own idling pattern and register setting.
      for (int phase = 1; phase <= 4; phase++) begin
         drain();
         repeat (SETTLE_CYCLES) @(posedge clock);
         case (phase)
            1: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               write_csr(CSR_INTEGRAL_LIMIT, 31'($urandom_range(32'h0100_0000, 32'h0001_0000)));
               write_csr(CSR_SAMPLE_PERIOD, 31'd16777);
            end
            2: begin
               send_idle_pct = 48;
               recv_stall_pct = 0;
               write_csr(CSR_INTEGRAL_LIMIT, 31'd0);
               write_csr(CSR_SAMPLE_PERIOD, 31'd0);
            end
            3: begin
               send_idle_pct = 0;
               recv_stall_pct = 48;
               write_csr(CSR_INTEGRAL_LIMIT, 31'h7FFF_FFFF);
               write_csr(CSR_SAMPLE_PERIOD, 31'($urandom_range(32'h00FF_FFFF)));
            end
            default: begin
               send_idle_pct = 28;
               recv_stall_pct = 28;
               write_csr(CSR_INTEGRAL_LIMIT, 31'($urandom_range(32'h0004_0000, 1)));
               write_csr(CSR_SAMPLE_PERIOD, 31'h00FF_FFFF);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off mid-phase until the block has emptied out
            if (phase == 2 && n == PHASE_ITEMS / 2) drain();
            send_req(rand_req());
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
